// ===== design/bucketed_tick_task_scheduler_defines.svh =====
// assertion macros for the bucketed tick task scheduler
// used by files that check behavior; expands to nothing when SYNTHESIS is defined
`ifndef BUCKETED_TICK_TASK_SCHEDULER_DEFINES_SVH
`define BUCKETED_TICK_TASK_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define BTTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BTTS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BTTS_ASSERT(lbl, prop, msg)
`define BTTS_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/btts_pkg.sv =====
// shared types and constants for the bucketed tick task scheduler
// no dependencies
package btts_pkg;
	localparam int unsigned DEF_MAX_BUCKETS      = 8;
	localparam int unsigned DEF_SLOTS_PER_BUCKET = 16;
	localparam int unsigned BKT_W                = 4;
	localparam logic [31:0] FIRST_HANDLE         = 32'd1000;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_TICK   = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_FIRED  = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [31:0] payload;
		logic [15:0] delay;
		logic [15:0] repeat_cnt;
		logic [3:0]  prio;
		logic [31:0] handle;
	} slot_t;

	typedef struct packed {
		logic latch;
		logic add_go;
		logic rd_issue;
		logic bkt_next;
		logic idx_inc;
		logic sh_wr;
		logic rm_found;
		logic rm_miss;
		logic tk_proc;
		logic tk_done;
	} cmd_t;

	typedef struct packed {
		logic bkt_end;
		logic idx_end;
		logic hit;
	} stat_t;
endpackage

// ===== design/btts_ctrl.sv =====
// controller state machine: sequences add, remove search/shift and tick walk
// depends on btts_pkg
module btts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      req_type,
	input  btts_pkg::stat_t stat,
	output btts_pkg::cmd_t  cmd,
	output logic            busy
);
	import btts_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_ADD     = 8'b0000_0010,
		ST_RM_RD   = 8'b0000_0100,
		ST_RM_CMP  = 8'b0000_1000,
		ST_SH_RD   = 8'b0001_0000,
		ST_SH_WR   = 8'b0010_0000,
		ST_TK_RD   = 8'b0100_0000,
		ST_TK_PROC = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					case (req_type)
						REQ_ADD:    state_d = ST_ADD;
						REQ_REMOVE: state_d = ST_RM_RD;
						REQ_TICK:   state_d = ST_TK_RD;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				cmd.add_go = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_RM_RD: begin
				if (stat.bkt_end) begin
					cmd.rm_miss = 1'b1;
					state_d     = ST_IDLE;
				end else if (stat.idx_end) begin
					cmd.bkt_next = 1'b1;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_RM_CMP;
				end
			end
			ST_RM_CMP: begin
				cmd.idx_inc = 1'b1;
				state_d     = stat.hit ? ST_SH_RD : ST_RM_RD;
			end
			ST_SH_RD: begin
				if (stat.idx_end) begin
					cmd.rm_found = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_SH_WR;
				end
			end
			ST_SH_WR: begin
				cmd.sh_wr = 1'b1;
				state_d   = ST_SH_RD;
			end
			ST_TK_RD: begin
				if (stat.idx_end) begin
					cmd.tk_done = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_TK_PROC;
				end
			end
			ST_TK_PROC: begin
				cmd.tk_proc = 1'b1;
				state_d     = ST_TK_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);
endmodule

// ===== design/btts_dpath.sv =====
// datapath: slot memory, bucket fill counts, handle counter, walk counters, result registers
// depends on btts_pkg
module btts_dpath #(
	parameter int unsigned MAX_BUCKETS      = btts_pkg::DEF_MAX_BUCKETS,
	parameter int unsigned SLOTS_PER_BUCKET = btts_pkg::DEF_SLOTS_PER_BUCKET
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_data,
	input  logic [1:0]      req_type,
	input  logic [2:0]      tick_phase,
	input  logic [3:0]      prio_level,
	input  logic [15:0]     task_tag,
	input  logic [31:0]     task_payload,
	input  logic [15:0]     start_delay,
	input  logic [15:0]     repeat_count,
	input  logic [31:0]     target_handle,
	input  btts_pkg::cmd_t  cmd,
	output btts_pkg::stat_t stat,
	output logic            result_strobe,
	output logic [1:0]      result_kind,
	output logic [31:0]     task_handle,
	output logic            ok_flag,
	output logic [15:0]     fired_tag,
	output logic [31:0]     fired_payload,
	output logic            last_flag
);
	import btts_pkg::*;

	localparam int unsigned DEPTH = MAX_BUCKETS * SLOTS_PER_BUCKET;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned BIW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int unsigned FW    = $clog2(SLOTS_PER_BUCKET + 1);

	function automatic logic [AW-1:0] slot_addr(input logic [BIW-1:0] bkt,
			input logic [FW-1:0] idx);
		slot_addr = AW'(32'(bkt) * 32'(SLOTS_PER_BUCKET) + 32'(idx));
	endfunction

	logic [1:0]       log2_q;
	logic [BKT_W-1:0] b_q;
	logic [FW-1:0]    i_q, w_q;
	logic [FW-1:0]    fill_q [MAX_BUCKETS];
	logic [31:0]      nh_q;
	logic [3:0]       prio_q;
	logic [15:0]      tag_q, delay_q, rep_q;
	logic [31:0]      pay_q, target_q;
	slot_t            mem [DEPTH];
	slot_t            rdata_q;

	// buckets in use and tick bucket
	logic [BKT_W-1:0] pow2, used;
	logic [2:0]       mask;
	logic [BIW-1:0]   bidx;
	logic             b_valid;
	logic [FW-1:0]    cur_fill;

	assign pow2     = BKT_W'(1) << log2_q;
	assign used     = (pow2 > BKT_W'(MAX_BUCKETS)) ? BKT_W'(MAX_BUCKETS) : pow2;
	assign mask     = 3'((4'(1) << log2_q) - 4'(1));
	assign bidx     = b_q[BIW-1:0];
	assign b_valid  = (b_q < used);
	assign cur_fill = b_valid ? fill_q[bidx] : '0;

	assign stat.bkt_end = (b_q >= used);
	assign stat.idx_end = !b_valid || (i_q >= cur_fill);
	assign stat.hit     = (rdata_q.handle == target_q);

	// emptiest bucket in use, lowest index on a tie
	logic [BIW-1:0] best;
	logic [FW-1:0]  bestf;
	logic           full;

	always_comb begin
		best  = '0;
		bestf = fill_q[0];
		for (int k = 1; k < MAX_BUCKETS; k++) begin
			if ((BKT_W'(k) < used) && (fill_q[k] < bestf)) begin
				best  = BIW'(k);
				bestf = fill_q[k];
			end
		end
	end
	assign full = (bestf >= FW'(SLOTS_PER_BUCKET));

	// tick pass slot update
	logic  match, fire, keep;
	slot_t upd;

	always_comb begin
		upd   = rdata_q;
		keep  = 1'b1;
		match = (rdata_q.prio == prio_q);
		fire  = match && (rdata_q.delay == 16'd0);
		if (fire) begin
			if (rdata_q.repeat_cnt != 16'd0) begin
				upd.repeat_cnt = rdata_q.repeat_cnt - 16'd1;
				keep           = (upd.repeat_cnt != 16'd0);
			end
		end else if (match) begin
			upd.delay = rdata_q.delay - 16'd1;
		end
	end

	// single write port
	logic          we;
	logic [AW-1:0] waddr;
	slot_t         wdata;

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = rdata_q;
		if (cmd.add_go && !full) begin
			we    = 1'b1;
			waddr = slot_addr(best, bestf);
			wdata = '{tag: tag_q, payload: pay_q, delay: delay_q, repeat_cnt: rep_q,
				prio: prio_q, handle: nh_q};
		end else if (cmd.sh_wr) begin
			we    = 1'b1;
			waddr = slot_addr(bidx, i_q - FW'(1));
		end else if (cmd.tk_proc && keep) begin
			we    = 1'b1;
			waddr = slot_addr(bidx, w_q);
			wdata = upd;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (cmd.rd_issue) rdata_q <= mem[slot_addr(bidx, i_q)];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q <= 2'd0;
			nh_q   <= FIRST_HANDLE;
			b_q    <= '0;
			i_q    <= '0;
			w_q    <= '0;
			for (int k = 0; k < MAX_BUCKETS; k++) fill_q[k] <= '0;
		end else begin
			if (cfg_we) log2_q <= cfg_data;
			if (cmd.latch) begin
				b_q <= (req_type == REQ_TICK) ? BKT_W'(tick_phase & mask) : '0;
				i_q <= '0;
				w_q <= '0;
			end
			if (cmd.bkt_next) begin
				b_q <= b_q + BKT_W'(1);
				i_q <= '0;
			end
			if (cmd.idx_inc || cmd.sh_wr || cmd.tk_proc) i_q <= i_q + FW'(1);
			if (cmd.tk_proc && keep) w_q <= w_q + FW'(1);
			if (cmd.add_go && !full) begin
				fill_q[best] <= bestf + FW'(1);
				nh_q         <= nh_q + 32'd1;
			end
			if (cmd.rm_found) fill_q[bidx] <= fill_q[bidx] - FW'(1);
			if (cmd.tk_done && b_valid) fill_q[bidx] <= w_q;
		end
	end

	// request fields
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			prio_q   <= prio_level;
			tag_q    <= task_tag;
			pay_q    <= task_payload;
			delay_q  <= start_delay;
			rep_q    <= repeat_count;
			target_q <= target_handle;
		end
	end

	// result registers
	logic        emit;
	logic [1:0]  kind_d;
	logic [31:0] handle_d;
	logic        ok_d, last_d;
	logic [15:0] tag_d;
	logic [31:0] pay_d;

	assign emit = cmd.add_go || cmd.rm_found || cmd.rm_miss || cmd.tk_done ||
		(cmd.tk_proc && fire);

	always_comb begin
		kind_d   = KIND_FIRED;
		handle_d = rdata_q.handle;
		ok_d     = 1'b1;
		tag_d    = rdata_q.tag;
		pay_d    = rdata_q.payload;
		last_d   = 1'b0;
		if (cmd.add_go) begin
			kind_d   = KIND_ADD;
			handle_d = full ? 32'd0 : nh_q;
			ok_d     = !full;
			tag_d    = '0;
			pay_d    = '0;
			last_d   = 1'b1;
		end else if (cmd.rm_found || cmd.rm_miss) begin
			kind_d   = KIND_REMOVE;
			handle_d = target_q;
			ok_d     = cmd.rm_found;
			tag_d    = '0;
			pay_d    = '0;
			last_d   = 1'b1;
		end else if (cmd.tk_done) begin
			kind_d   = KIND_DONE;
			handle_d = '0;
			tag_d    = '0;
			pay_d    = '0;
			last_d   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_strobe <= 1'b0;
		else result_strobe <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_kind   <= kind_d;
			task_handle   <= handle_d;
			ok_flag       <= ok_d;
			fired_tag     <= tag_d;
			fired_payload <= pay_d;
			last_flag     <= last_d;
		end
	end
endmodule

// ===== design/bucketed_tick_task_scheduler.sv =====
// Bucketed tick task scheduler. A request is taken when start is high and busy is low; each
// result is shown for one cycle with result_strobe and cannot be held off, and last_flag marks
// the final result of a request. Work runs through one slot memory port (one read, one write per
// cycle): an add writes one slot; a remove reads and compares slots bucket by bucket until it hits,
// then shifts the later slots of that bucket down one by one; a tick pass reads, updates and
// writes back each slot of the tick bucket in turn. No clearing pass is needed after reset.
// depends on btts_pkg, btts_ctrl, btts_dpath and the defines header
`include "bucketed_tick_task_scheduler_defines.svh"
module bucketed_tick_task_scheduler #(
	parameter int unsigned MAX_BUCKETS      = btts_pkg::DEF_MAX_BUCKETS,
	parameter int unsigned SLOTS_PER_BUCKET = btts_pkg::DEF_SLOTS_PER_BUCKET
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [2:0]  tick_phase,
	input  logic [3:0]  prio_level,
	input  logic [15:0] task_tag,
	input  logic [31:0] task_payload,
	input  logic [15:0] start_delay,
	input  logic [15:0] repeat_count,
	input  logic [31:0] target_handle,
	output logic        result_strobe,
	output logic [1:0]  result_kind,
	output logic [31:0] task_handle,
	output logic        ok_flag,
	output logic [15:0] fired_tag,
	output logic [31:0] fired_payload,
	output logic        last_flag
);
	import btts_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	btts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	btts_dpath #(
		.MAX_BUCKETS      (MAX_BUCKETS),
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.tick_phase    (tick_phase),
		.prio_level    (prio_level),
		.task_tag      (task_tag),
		.task_payload  (task_payload),
		.start_delay   (start_delay),
		.repeat_count  (repeat_count),
		.target_handle (target_handle),
		.cmd           (cmd),
		.stat          (stat),
		.result_strobe (result_strobe),
		.result_kind   (result_kind),
		.task_handle   (task_handle),
		.ok_flag       (ok_flag),
		.fired_tag     (fired_tag),
		.fired_payload (fired_payload),
		.last_flag     (last_flag)
	);

	// the closing transaction of a request coincides with the return to idle
	`BTTS_ASSERT(a_last_frees, result_strobe && last_flag |-> !busy, "busy after last result")
	// only fired results may be followed by more results of the same request
	`BTTS_NEVER(a_kind_last, result_strobe && !last_flag && (result_kind != KIND_FIRED), "non-fire result not last")
	// no result can come out in the cycle right after a request is taken
	`BTTS_ASSERT(a_no_early, start && !busy |=> !result_strobe, "result right after accept")
endmodule
